/* sv/deq_pkg.sv */
package deq_pkg;

	// Default ring capacity
	localparam int CAPACITY_DEF = 1024;

	// Field widths of the request and response channels
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OUT_RANGE = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture the request
		logic exec;     // run the command against pointers and store
		logic capture;  // take the store read data as the result
		logic publish;  // move the finished result into the output register
	} dp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic needs_read;  // the command reads the store
	} dp_stat_t;

endpackage

/* sv/deq_ifs.sv */
interface deq_req_if;
	logic                           valid;
	logic                           ready;
	logic [deq_pkg::CMD_W-1:0]      cmd;
	logic signed [deq_pkg::VALUE_W-1:0] push_value;
	logic [deq_pkg::POS_W-1:0]      position;

	modport source (output valid, output cmd, output push_value, output position,
		input ready);
	modport sink (input valid, input cmd, input push_value, input position,
		output ready);
endinterface

interface deq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [deq_pkg::VALUE_W-1:0] read_value;
	logic [deq_pkg::STATUS_W-1:0]       status;
	logic [deq_pkg::COUNT_W-1:0]        element_count;

	modport source (output valid, output read_value, output status,
		output element_count, input ready);
	modport sink (input valid, input read_value, input status,
		input element_count, output ready);
endinterface

/* sv/deq_ram.sv */
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/deq_ctrl.sv */
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  deq_pkg::dp_stat_t  stat,
	output deq_pkg::dp_ctrl_t  ctrl
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q, state_next;
	logic   rsp_full_q;
	logic   publish;

	// The output register takes a new result when it is empty or being emptied
	assign publish = (state_q == ST_DONE) && (!rsp_full_q || rsp_ready);

	// Sequence one request: take it, run it, wait on the store if it reads, hand off the result
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				state_next = stat.needs_read ? ST_WAIT : ST_DONE;
			end
			ST_WAIT: begin
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (publish) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Track whether the output register holds a response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_full_q <= 1'b0;
		end else if (publish) begin
			rsp_full_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_full_q <= 1'b0;
		end
	end

	// Drive handshakes and datapath commands
	assign req_ready    = (state_q == ST_IDLE);
	assign rsp_valid    = rsp_full_q;
	assign ctrl.load    = (state_q == ST_IDLE) && req_valid;
	assign ctrl.exec    = (state_q == ST_EXEC);
	assign ctrl.capture = (state_q == ST_WAIT);
	assign ctrl.publish = publish;

endmodule

/* sv/deq_dp.sv */
module deq_dp #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  deq_pkg::dp_ctrl_t                   ctrl,
	output deq_pkg::dp_stat_t                   stat,
	input  logic [deq_pkg::CMD_W-1:0]           cmd,
	input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
	input  logic [deq_pkg::POS_W-1:0]           position,
	output logic signed [deq_pkg::VALUE_W-1:0]  read_value,
	output logic [deq_pkg::STATUS_W-1:0]        status,
	output logic [deq_pkg::COUNT_W-1:0]         element_count
);

	localparam int PW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;
	localparam int SUMW = ((PW > deq_pkg::POS_W) ? PW : deq_pkg::POS_W) + 1;

	// Request registers
	logic [deq_pkg::CMD_W-1:0]   cmd_q;
	logic [deq_pkg::VALUE_W-1:0] word_q;
	logic [deq_pkg::POS_W-1:0]   pos_q;

	// Ring state
	logic [PW-1:0] front_q;
	logic [PW-1:0] back_q;
	logic [CW-1:0] count_q;

	// Response registers
	logic [deq_pkg::VALUE_W-1:0]  value_q;
	logic [deq_pkg::STATUS_W-1:0] status_q;

	// Output register
	logic [deq_pkg::VALUE_W-1:0]  rsp_value_q;
	logic [deq_pkg::STATUS_W-1:0] rsp_status_q;
	logic [deq_pkg::COUNT_W-1:0]  rsp_count_q;

	// Store ports
	logic                        mem_we;
	logic [PW-1:0]               mem_waddr;
	logic                        mem_re;
	logic [PW-1:0]               mem_raddr;
	logic [deq_pkg::VALUE_W-1:0] mem_rdata;

	logic [PW-1:0]               front_next;
	logic [PW-1:0]               back_next;
	logic [CW-1:0]               count_next;
	logic [deq_pkg::STATUS_W-1:0] status_next;
	logic [SUMW-1:0]             pos_sum;
	logic                        is_full;
	logic                        is_empty;
	logic                        in_range;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] s);
		logic [PW:0] inc;
		inc = {1'b0, s} + (PW+1)'(1);
		return (inc >= (PW+1)'(CAPACITY)) ? '0 : inc[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] s);
		return (s == '0) ? PW'(CAPACITY - 1) : s - PW'(1);
	endfunction

	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign in_range = (CMPW'(pos_q) < CMPW'(count_q));

	// Slot of the element at the requested position, wrapped once
	always_comb begin
		pos_sum = SUMW'(front_q) + SUMW'(pos_q);
		if (pos_sum >= SUMW'(CAPACITY)) begin
			pos_sum = pos_sum - SUMW'(CAPACITY);
		end
	end

	// Decode the command into store access, pointer moves and status
	always_comb begin
		front_next  = front_q;
		back_next   = back_q;
		count_next  = count_q;
		status_next = deq_pkg::STAT_OK;
		mem_we      = 1'b0;
		mem_waddr   = back_q;
		mem_re      = 1'b0;
		mem_raddr   = front_q;
		case (cmd_q)
			deq_pkg::CMD_PUSH_BACK: begin
				if (is_full) begin
					status_next = deq_pkg::STAT_FULL;
				end else begin
					mem_we     = 1'b1;
					mem_waddr  = back_q;
					back_next  = ring_next(back_q);
					count_next = count_q + CW'(1);
				end
			end
			deq_pkg::CMD_PUSH_FRONT: begin
				if (is_full) begin
					status_next = deq_pkg::STAT_FULL;
				end else begin
					mem_we     = 1'b1;
					front_next = ring_prev(front_q);
					mem_waddr  = front_next;
					count_next = count_q + CW'(1);
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (is_empty) begin
					status_next = deq_pkg::STAT_EMPTY;
				end else begin
					mem_re     = 1'b1;
					back_next  = ring_prev(back_q);
					mem_raddr  = back_next;
					count_next = count_q - CW'(1);
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (is_empty) begin
					status_next = deq_pkg::STAT_EMPTY;
				end else begin
					mem_re     = 1'b1;
					mem_raddr  = front_q;
					front_next = ring_next(front_q);
					count_next = count_q - CW'(1);
				end
			end
			deq_pkg::CMD_READ_AT: begin
				if (!in_range) begin
					status_next = deq_pkg::STAT_OUT_RANGE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = pos_sum[PW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.needs_read = mem_re;

	// Hold the request while it is worked on
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q  <= cmd;
			word_q <= push_value;
			pos_q  <= position;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (ctrl.exec) begin
			front_q <= front_next;
			back_q  <= back_next;
			count_q <= count_next;
		end
	end

	// Build the response: status at execute, read data in the wait state that follows
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			status_q <= status_next;
			value_q  <= '0;
		end else if (ctrl.capture) begin
			value_q  <= mem_rdata;
		end
	end

	// Move the finished result into the output register
	always_ff @(posedge clk) begin
		if (ctrl.publish) begin
			rsp_value_q  <= value_q;
			rsp_status_q <= status_q;
			rsp_count_q  <= deq_pkg::COUNT_W'(count_q);
		end
	end

	deq_ram #(
		.WIDTH (deq_pkg::VALUE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ctrl.exec && mem_we),
		.waddr (mem_waddr),
		.wdata (word_q),
		.re    (ctrl.exec && mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign read_value    = rsp_value_q;
	assign status        = rsp_status_q;
	assign element_count = rsp_count_q;

endmodule

/* sv/double_ended_queue_top.sv */
// Double-ended queue over a ring of CAPACITY words in one RAM with registered read.
// A request executes in the cycle after it is taken; a pop or read that hits then waits
// on the RAM in a wait state, and the result enters the output register from the done
// state once that register is empty or being emptied. A new request is taken only after
// the last result has entered the output register; a stalled response holds the input
// only once the next result is also done. Reset clears pointers, count and response valid.
module double_ended_queue_top #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input logic       clk,
	input logic       arst_n,
	deq_req_if.sink   req_ch,
	deq_rsp_if.source rsp_ch
);

	deq_pkg::dp_ctrl_t ctrl;
	deq_pkg::dp_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	deq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.cmd           (req_ch.cmd),
		.push_value    (req_ch.push_value),
		.position      (req_ch.position),
		.read_value    (rsp_ch.read_value),
		.status        (rsp_ch.status),
		.element_count (rsp_ch.element_count)
	);

endmodule
